### rtl/core/vwh_pkg.sv
// ----------------------------------------------------------------------------
// vwh_pkg
// Shared constants, types and the key fold step of the vertex weld table.
// ----------------------------------------------------------------------------
package vwh_pkg;

  localparam int VERTEX_CAPACITY = 4096;
  localparam int TABLE_SLOTS     = 8192;   // power of two

  localparam int KEY_W    = 64;
  localparam int COORD_W  = 32;
  localparam int VIDX_W   = 12;
  localparam int SLOT_W   = $clog2(TABLE_SLOTS);
  localparam int SIDX_W   = $clog2(VERTEX_CAPACITY);
  localparam int CNT_W    = SIDX_W + 1;
  localparam int TAG_W    = 4;
  localparam int ENTRY_W  = TAG_W + SIDX_W + KEY_W;

  localparam logic [KEY_W-1:0] KEY_SEED = 64'd1469598103934665603;
  localparam logic [TAG_W-1:0] TAG_NONE  = '0;
  localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] TAG_LAST  = '1;

  typedef struct packed {
    logic             first;
    logic [KEY_W-1:0] key;
  } vwh_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIDX_W-1:0] idx;
    logic [KEY_W-1:0]  key;
  } vwh_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SWEEP,
    B_LOOK,
    B_CMP
  } vwh_back_state_t;

  // xor one word in, then multiply by 1099511628211 = 2^40 + 0x1B3 (mod 2^64)
  function automatic logic [KEY_W-1:0] fold_step(input logic [KEY_W-1:0] h,
                                                 input logic [COORD_W-1:0] w);
    logic [KEY_W-1:0] t;
    t = h ^ {{(KEY_W-COORD_W){1'b0}}, w};
    return (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
  endfunction

endpackage

### rtl/core/stl_vertex_weld_hash_table.sv
// ----------------------------------------------------------------------------
// stl_vertex_weld_hash_table
// Vertex weld table: maps repeated vertices onto shared dense indices.
// ----------------------------------------------------------------------------
// Usage:
//   in channel carries one vertex per item: three raw 32-bit coordinate words
//   in tdata and the first-of-model flag in tuser. A set flag empties the
//   table and restarts numbering at 0 before the vertex is handled.
//   out channel returns one item per vertex: its shared index, a new flag and
//   a full flag (index 0 when a new key could not be stored).
// Path: the fold stages, then the queue, then the back end, which pops the
//   item and runs a look state and a compare state for each probed slot;
//   the compare that ends the search loads the output register.
// Pacing: the back end takes a new item only when idle, after the last
//   search ends; each probed slot is a read on the slot RAM's one read port.
// Clearing a model bumps a 4-bit slot tag; every 15th clear the tag wraps and
//   the back end sweeps all 8192 slots before that vertex.
// Reset: a sweep over all 8192 slots marks them empty; in_tready stays low
//   until it ends.
// A stalled receiver holds the result register; the fold pipeline and the
//   two-entry queue keep taking items until they fill.
// ----------------------------------------------------------------------------
module stl_vertex_weld_hash_table import vwh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // x_bits, y_bits, z_bits
  input  logic         in_tuser,   // first_of_model
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata   // index, new flag, full flag, 2'b0
);

  logic      q_in_valid, q_in_ready, q_out_valid, q_out_ready, init_done;
  vwh_item_t q_in_item, q_out_item;
  logic [VIDX_W-1:0] out_index;
  logic      out_new, out_full;

  // fold x, y, z into the 64-bit key
  vwh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (init_done),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_first (in_tuser),
    .in_x     (in_tdata[31:0]),
    .in_y     (in_tdata[63:32]),
    .in_z     (in_tdata[95:64]),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_item   (q_in_item)
  );

  // decouple folding from probing
  vwh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_in_valid),
    .wr_ready (q_in_ready),
    .wr_item  (q_in_item),
    .rd_valid (q_out_valid),
    .rd_ready (q_out_ready),
    .rd_item  (q_out_item)
  );

  // probe, insert and hold the result
  vwh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_item    (q_out_item),
    .init_done (init_done),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_index (out_index),
    .out_new   (out_new),
    .out_full  (out_full)
  );

  assign out_tdata = {2'b00, out_full, out_new, out_index};

`ifndef SYNTHESIS
  a_new_full_excl: assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> !(out_tdata[12] && out_tdata[13]))
    else $error("result both new and full");

  a_full_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_tvalid && out_tdata[13]) |-> (out_tdata[11:0] == 12'd0))
    else $error("full result with nonzero index");

  a_reset_blocks_input: assert property (@(posedge clk)
    rst |=> !in_tready)
    else $error("input accepted right after reset");
`endif

endmodule

### rtl/core/vwh_ram.sv
// ----------------------------------------------------------------------------
// vwh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vwh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/vwh_front.sv
// ----------------------------------------------------------------------------
// vwh_front
// Three-stage key fold pipeline: one coordinate word per stage.
// ----------------------------------------------------------------------------
module vwh_front import vwh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_first,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  input  logic [COORD_W-1:0] in_z,
  output logic               q_valid,
  input  logic               q_ready,
  output vwh_item_t          q_item
);

  logic v1, v2, v3;
  logic r1, r2, r3;
  logic f1, f2, f3;
  logic [KEY_W-1:0]   h1, h2, h3;
  logic [COORD_W-1:0] y1, z1, z2;

  assign r3       = !v3 || q_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1 && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid && en;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      f1 <= in_first;
      h1 <= fold_step(KEY_SEED, in_x);
      y1 <= in_y;
      z1 <= in_z;
    end
    if (r2) begin
      f2 <= f1;
      h2 <= fold_step(h1, y1);
      z2 <= z1;
    end
    if (r3) begin
      f3 <= f2;
      h3 <= fold_step(h2, z2);
    end
  end

  assign q_valid     = v3;
  assign q_item.first = f3;
  assign q_item.key   = h3;

endmodule

### rtl/core/vwh_queue.sv
// ----------------------------------------------------------------------------
// vwh_queue
// Two-entry queue of folded keys between front and back.
// ----------------------------------------------------------------------------
module vwh_queue import vwh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  vwh_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output vwh_item_t rd_item
);

  vwh_item_t  slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

### rtl/core/vwh_back.sv
// ----------------------------------------------------------------------------
// vwh_back
// Probe sequencer: linear probing over the slot RAM, insert, result register.
// ----------------------------------------------------------------------------
module vwh_back import vwh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  vwh_item_t         q_item,
  output logic              init_done,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VIDX_W-1:0] out_index,
  output logic              out_new,
  output logic              out_full
);

  vwh_back_state_t state, state_next;
  logic [SLOT_W-1:0] pos, probes, sweep_addr;
  logic [TAG_W-1:0]  cur_tag;
  logic [CNT_W-1:0]  nfree;
  logic [KEY_W-1:0]  key_r;
  logic              look_after_sweep;

  vwh_entry_t rd_entry, wr_entry;
  logic       wr_en;
  logic [SLOT_W-1:0] wr_addr;

  logic out_free, hit, empty, done, res_new, res_full;
  logic [VIDX_W-1:0] res_index;

  vwh_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (pos),
    .rd_data (rd_entry)
  );

  assign out_free = !out_valid || out_ready;
  assign empty    = (rd_entry.tag != cur_tag);
  assign hit      = !empty && (rd_entry.key == key_r);
  assign q_ready  = (state == B_IDLE) && init_done;

  always_comb begin
    state_next = state;
    done       = 1'b0;
    res_new    = 1'b0;
    res_full   = 1'b0;
    res_index  = '0;
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_entry.tag = cur_tag;
    wr_entry.idx = nfree[SIDX_W-1:0];
    wr_entry.key = key_r;
    unique case (state)
      B_IDLE: begin
        if (q_valid && init_done) begin
          state_next = B_LOOK;
          if (q_item.first && cur_tag == TAG_LAST) state_next = B_SWEEP;
        end
      end
      B_SWEEP: begin
        wr_en        = 1'b1;
        wr_addr      = sweep_addr;
        wr_entry.tag = TAG_NONE;
        if (sweep_addr == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_next = look_after_sweep ? B_LOOK : B_IDLE;
        end
      end
      B_LOOK: begin
        state_next = B_CMP;
      end
      B_CMP: begin
        if (hit) begin
          done      = 1'b1;
          res_index = VIDX_W'(rd_entry.idx);
        end else if (empty) begin
          done = 1'b1;
          if (nfree >= CNT_W'(VERTEX_CAPACITY)) begin
            res_full = 1'b1;
          end else begin
            res_new   = 1'b1;
            res_index = VIDX_W'(nfree[SIDX_W-1:0]);
            wr_en     = out_free;
          end
        end else if (probes == SLOT_W'(TABLE_SLOTS - 1)) begin
          done     = 1'b1;
          res_full = 1'b1;
        end else begin
          state_next = B_LOOK;
        end
        if (done && out_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= B_SWEEP;
      sweep_addr       <= '0;
      cur_tag          <= TAG_FIRST;
      nfree            <= '0;
      init_done        <= 1'b0;
      look_after_sweep <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CMP && done && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid && init_done) begin
            key_r  <= q_item.key;
            pos    <= q_item.key[SLOT_W-1:0];
            probes <= '0;
            if (q_item.first) begin
              nfree <= '0;
              if (cur_tag == TAG_LAST) begin
                sweep_addr       <= '0;
                look_after_sweep <= 1'b1;
              end else begin
                cur_tag <= cur_tag + TAG_W'(1);
              end
            end
          end
        end
        B_SWEEP: begin
          sweep_addr <= sweep_addr + SLOT_W'(1);
          if (sweep_addr == SLOT_W'(TABLE_SLOTS - 1)) begin
            cur_tag   <= TAG_FIRST;
            init_done <= 1'b1;
          end
        end
        B_CMP: begin
          if (!done) begin
            pos    <= pos + SLOT_W'(1);
            probes <= probes + SLOT_W'(1);
          end else if (out_free) begin
            out_index <= res_index;
            out_new   <= res_new;
            out_full  <= res_full;
            if (res_new) nfree <= nfree + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex weld table: streams vertices with random
// handshake gaps and checks every index, new flag and full flag.
// ----------------------------------------------------------------------------

// Weld predictor plus the queue of results still owed by the block.
class weld_scoreboard;
  localparam int SLOTS    = vwh_pkg::TABLE_SLOTS;
  localparam int CAPACITY = vwh_pkg::VERTEX_CAPACITY;
  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

  bit          slot_used [SLOTS];
  logic [63:0] slot_key  [SLOTS];
  int unsigned slot_vidx [SLOTS];
  int unsigned stored_cnt;
  logic [15:0] owed_q[$];
  int          mismatches;

  function new();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    stored_cnt = 0;
    mismatches = 0;
  endfunction

  function automatic logic [63:0] vertex_key(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
    logic [63:0] h;
    h = vwh_pkg::KEY_SEED;
    h = (h ^ {32'd0, x}) * FNV_PRIME;
    h = (h ^ {32'd0, y}) * FNV_PRIME;
    h = (h ^ {32'd0, z}) * FNV_PRIME;
    return h;
  endfunction

  // Work out the result of one accepted vertex and queue it.
  function void note_vertex(bit first, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
    logic [63:0] key;
    int          pos;
    logic [11:0] vidx;
    bit          fresh;
    bit          full;
    bit          found;
    if (first) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      stored_cnt = 0;
    end
    key   = vertex_key(x, y, z);
    pos   = int'(key % SLOTS);
    found = 1'b0;
    fresh = 1'b0;
    full  = 1'b0;
    vidx  = '0;
    // walk the probe chain until a hit or an empty slot
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used[pos]) break;
      if (slot_key[pos] == key) begin
        found = 1'b1;
        vidx  = slot_vidx[pos][11:0];
        break;
      end
      pos = (pos + 1) % SLOTS;
    end
    if (!found) begin
      if (slot_used[pos] || stored_cnt >= CAPACITY) begin
        full = 1'b1;
      end else begin
        slot_used[pos] = 1'b1;
        slot_key[pos]  = key;
        slot_vidx[pos] = stored_cnt;
        vidx           = stored_cnt[11:0];
        fresh          = 1'b1;
        stored_cnt++;
      end
    end
    owed_q.insert(owed_q.size(), {2'b00, full, fresh, vidx});
  endfunction

  function void check_result(logic [15:0] got);
    logic [15:0] want;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = owed_q.pop_front();
    if (got[11:0] !== want[11:0] || got[12] !== want[12] || got[13] !== want[13]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: index %0d/%0d new %b/%b full %b/%b (want/got)",
                 want[11:0], got[11:0], want[12], got[12], want[13], got[13]);
    end
  endfunction
endclass

module tb_top;

  logic        clk;
  logic        rst;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // x_bits, y_bits, z_bits
  logic        in_tuser;   // first_of_model
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // index, new flag, full flag, 2'b0

  weld_scoreboard weld_sb;
  bit             gaps_on;     // random idling on both sides
  int             long_hold;   // receiver hold-off requested by the stimulus
  logic [95:0]    model_pool[$];

  stl_vertex_weld_hash_table u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Offer one vertex and hold it until the block takes it.
  task automatic send_vertex(bit first, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= first;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    weld_sb.note_vertex(first, x, y, z);
  endtask

  // Random coordinate word, biased toward the extremes now and then.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // One model: mostly repeats of its own vertices, some fresh ones.
  task automatic send_model(int len);
    logic [95:0] v;
    model_pool.delete();
    for (int i = 0; i < len; i++) begin
      if (model_pool.size() > 0 && $urandom_range(0, 9) < 6)
        v = model_pool[$urandom_range(0, model_pool.size() - 1)];
      else begin
        v = {rand_word(), rand_word(), rand_word()};
        model_pool.insert(model_pool.size(), v);
      end
      send_vertex(i == 0, v[31:0], v[63:32], v[95:64]);
    end
  endtask

  // Receiver: check each taken result, idle in bursts, honor long holds.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) weld_sb.check_result(out_tdata);
      if (long_hold > 0) begin
        long_hold--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (gaps_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  initial begin
    #40000000;
    $display("stl_vertex_weld_hash_table test failed");
    $finish;
  end

  initial begin
    int sent;
    bit held;
    weld_sb   = new();
    gaps_on   = 1'b0;
    long_hold = 0;
    held      = 1'b0;
    rst       = 1'b1;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, repeats, and a clear over a known vertex.
    send_vertex(1'b1, 32'h0, 32'h0, 32'h0);
    send_vertex(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vertex(1'b0, 32'h0, 32'h0, 32'h0);
    send_vertex(1'b0, 32'h3F80_0000, 32'h0, 32'h0);
    send_vertex(1'b0, 32'h0, 32'h3F80_0000, 32'h0);
    send_vertex(1'b0, 32'h0, 32'h0, 32'h3F80_0000);
    send_vertex(1'b0, 32'h8000_0000, 32'h0, 32'h0);
    send_vertex(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vertex(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vertex(1'b0, 32'h0, 32'h0, 32'h0);

    // One large model of distinct vertices, then a known key and a new key.
    gaps_on = 1'b1;
    for (int i = 0; i < 600; i++)
      send_vertex(i == 0, i, 32'h1234_0000 ^ i, ~i);
    send_vertex(1'b0, 32'd5, 32'h1234_0005, ~32'd5);
    send_vertex(1'b0, 32'hDEAD_BEEF, 32'h0, 32'h1);

    // Random models; partway through, block the receiver for a long stretch.
    sent = 0;
    while (sent < 1200) begin
      int len;
      len = $urandom_range(2, 120);
      if (!held && sent > 300) begin
        long_hold = 400;
        held      = 1'b1;
      end
      if (sent > 1000) gaps_on = 1'b0;
      send_model(len);
      sent += len;
    end
    in_tvalid <= 1'b0;

    gaps_on = 1'b0;
    while (weld_sb.owed_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (weld_sb.mismatches == 0 && weld_sb.owed_q.size() == 0)
      $display("stl_vertex_weld_hash_table test passed");
    else
      $display("stl_vertex_weld_hash_table test failed");
    $finish;
  end
endmodule

### files.f
rtl/core/vwh_pkg.sv
rtl/core/vwh_ram.sv
rtl/core/vwh_front.sv
rtl/core/vwh_queue.sv
rtl/core/vwh_back.sv
rtl/core/stl_vertex_weld_hash_table.sv
dv/tb_top.sv
